### sv/nfcd_pkg.sv
// ----------------------------------------------------------------------------
// nfcd_pkg
// Types, constants and command codes of the NOR flash command decoder.
// ----------------------------------------------------------------------------
package nfcd_pkg;

    localparam int ADDR_BITS        = 24;
    localparam int DATA_BITS        = 16;
    localparam int ID_BITS          = 8;
    localparam int BUFFER_WORDS     = 16;
    localparam int UNLOCK_ADDR_BITS = 11;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int LEFT_BITS        = 5;

    localparam logic [31:0] UNLOCK_ADDR_1 = 32'h0000_0555;
    localparam logic [31:0] UNLOCK_ADDR_2 = 32'h0000_02AA;

    localparam logic [7:0] CMD_UNLOCK_1     = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK_2     = 8'h55;
    localparam logic [7:0] CMD_RESET        = 8'hF0;
    localparam logic [7:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0] CMD_BUFFER       = 8'h25;
    localparam logic [7:0] CMD_CONFIRM      = 8'h29;
    localparam logic [7:0] CMD_ERASE_SECTOR = 8'h30;
    localparam logic [7:0] CMD_ERASE_CHIP   = 8'h10;
    localparam logic [7:0] CMD_AUTOSELECT   = 8'h90;
    localparam logic [7:0] CMD_OTP          = 8'h88;

    localparam logic [7:0] ID_OFS_MANUF = 8'h00;
    localparam logic [7:0] ID_OFS_DEV_A = 8'h01;
    localparam logic [7:0] ID_OFS_DEV_B = 8'h0E;
    localparam logic [7:0] ID_OFS_DEV_C = 8'h0F;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MANUF = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEV_A = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEV_B = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEV_C = 2'd3;

    localparam logic [ID_BITS-1:0] MANUF_RESET = 8'd1;
    localparam logic [ID_BITS-1:0] DEV_A_RESET = 8'd126;
    localparam logic [ID_BITS-1:0] DEV_B_RESET = 8'd0;
    localparam logic [ID_BITS-1:0] DEV_C_RESET = 8'd0;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DONE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE           = 4'd0,
        PH_UNLOCK1        = 4'd1,
        PH_UNLOCKED       = 4'd2,
        PH_PROG_DATA      = 4'd3,
        PH_ERASE_SETUP    = 4'd4,
        PH_ERASE_UNLOCK1  = 4'd5,
        PH_ERASE_UNLOCKED = 4'd6,
        PH_BUF_COUNT      = 4'd7,
        PH_BUF_LOAD       = 4'd8,
        PH_BUF_CONFIRM    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        MODE_READ       = 3'd0,
        MODE_AUTOSELECT = 3'd1,
        MODE_OTP        = 3'd2,
        MODE_BUSY       = 3'd3,
        MODE_ABORT      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_PROGRAM      = 3'd0,
        KIND_ERASE_SECTOR = 3'd1,
        KIND_ERASE_CHIP   = 3'd2,
        KIND_LOAD_BUFFER  = 3'd3,
        KIND_PROG_BUFFER  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [ADDR_BITS-1:0] word_address;
        logic [DATA_BITS-1:0] write_word;
        logic [DATA_BITS-1:0] array_word;
    } item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_word;
        logic                 command_valid;
        kind_t                command_kind;
        logic [ADDR_BITS-1:0] command_address;
        logic [DATA_BITS-1:0] command_word;
        logic                 busy_res;
        logic                 buffer_abort;
        logic                 otp_selected;
    } result_t;

    typedef struct packed {
        phase_t               phase;
        mode_t                mode;
        logic [DATA_BITS-1:0] poll_target;
        logic [ADDR_BITS-1:0] buffer_sector;
        logic [LEFT_BITS-1:0] words_left;
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0] manufacturer_id;
        logic [ID_BITS-1:0] device_id_a;
        logic [ID_BITS-1:0] device_id_b;
        logic [ID_BITS-1:0] device_id_c;
    } cfg_t;

endpackage

### sv/nfcd_req_if.sv
// ----------------------------------------------------------------------------
// nfcd_req_if
// Bus access and engine event channel into the command decoder.
// ----------------------------------------------------------------------------
interface nfcd_req_if;
    import nfcd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [ADDR_BITS-1:0] word_address;
    logic [DATA_BITS-1:0] write_word;
    logic [DATA_BITS-1:0] array_word;

    modport source (
        output valid, operation, word_address, write_word, array_word,
        input  ready
    );

    modport sink (
        input  valid, operation, word_address, write_word, array_word,
        output ready
    );
endinterface

### sv/nfcd_rsp_if.sv
// ----------------------------------------------------------------------------
// nfcd_rsp_if
// Result channel of the command decoder: read data, engine command, status.
// ----------------------------------------------------------------------------
interface nfcd_rsp_if;
    import nfcd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] read_word;
    logic                 command_valid;
    logic [2:0]           command_kind;
    logic [ADDR_BITS-1:0] command_address;
    logic [DATA_BITS-1:0] command_word;
    logic                 busy_res;
    logic                 buffer_abort;
    logic                 otp_selected;

    modport source (
        output valid, read_word, command_valid, command_kind, command_address,
               command_word, busy_res, buffer_abort, otp_selected,
        input  ready
    );

    modport sink (
        input  valid, read_word, command_valid, command_kind, command_address,
               command_word, busy_res, buffer_abort, otp_selected,
        output ready
    );
endinterface

### sv/nfcd_cfg.sv
// ----------------------------------------------------------------------------
// nfcd_cfg
// Autoselect identification registers behind a plain write port.
// ----------------------------------------------------------------------------
module nfcd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nfcd_pkg::ID_BITS-1:0]        cfg_data,
    output nfcd_pkg::cfg_t                      cfg
);
    import nfcd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manufacturer_id <= MANUF_RESET;
            cfg_reg.device_id_a     <= DEV_A_RESET;
            cfg_reg.device_id_b     <= DEV_B_RESET;
            cfg_reg.device_id_c     <= DEV_C_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MANUF: cfg_reg.manufacturer_id <= cfg_data;
                REG_DEV_A: cfg_reg.device_id_a     <= cfg_data;
                REG_DEV_B: cfg_reg.device_id_b     <= cfg_data;
                REG_DEV_C: cfg_reg.device_id_c     <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

### sv/nfcd_decode.sv
// ----------------------------------------------------------------------------
// nfcd_decode
// Command sequence decoder: next state and result for one bus item.
// ----------------------------------------------------------------------------
module nfcd_decode (
    input  nfcd_pkg::state_t  st,
    input  nfcd_pkg::item_t   item,
    input  nfcd_pkg::cfg_t    cfg,
    output nfcd_pkg::state_t  st_next,
    output nfcd_pkg::result_t res
);
    import nfcd_pkg::*;

    logic [7:0]           cmd;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
    logic                 at_unlock1;
    logic                 at_unlock2;
    logic                 data_phase;

    assign addr = item.word_address;
    assign data = item.write_word;
    assign cmd  = item.write_word[7:0];

    assign at_unlock1 = addr[UNLOCK_ADDR_BITS-1:0] == UNLOCK_ADDR_1[UNLOCK_ADDR_BITS-1:0];
    assign at_unlock2 = addr[UNLOCK_ADDR_BITS-1:0] == UNLOCK_ADDR_2[UNLOCK_ADDR_BITS-1:0];
    assign data_phase = (st.phase == PH_PROG_DATA) || (st.phase == PH_BUF_COUNT) ||
                        (st.phase == PH_BUF_LOAD) || (st.phase == PH_BUF_CONFIRM);

    always_comb
    begin
        st_next = st;
        res     = '0;

        case (op_t'(item.operation))
            OP_READ:
            begin
                case (st.mode)
                    MODE_AUTOSELECT:
                    begin
                        case (addr[7:0])
                            ID_OFS_MANUF: res.read_word = {8'h00, cfg.manufacturer_id};
                            ID_OFS_DEV_A: res.read_word = {8'h00, cfg.device_id_a};
                            ID_OFS_DEV_B: res.read_word = {8'h00, cfg.device_id_b};
                            ID_OFS_DEV_C: res.read_word = {8'h00, cfg.device_id_c};
                            default:      res.read_word = '0;
                        endcase
                    end
                    MODE_BUSY, MODE_ABORT:
                        res.read_word = {8'h00, ~st.poll_target[7], 7'h00};
                    default:
                        res.read_word = item.array_word;
                endcase
            end

            OP_WRITE:
            begin
                if (st.mode == MODE_BUSY)
                begin
                end
                else if (st.mode == MODE_ABORT)
                begin
                    if (cmd == CMD_RESET)
                    begin
                        st_next.mode  = MODE_READ;
                        st_next.phase = PH_IDLE;
                    end
                end
                else if (cmd == CMD_RESET && !data_phase)
                begin
                    st_next.mode  = MODE_READ;
                    st_next.phase = PH_IDLE;
                end
                else
                begin
                    st_next.phase = PH_IDLE;
                    case (st.phase)
                        PH_IDLE:
                            if (cmd == CMD_UNLOCK_1 && at_unlock1)
                                st_next.phase = PH_UNLOCK1;
                        PH_UNLOCK1:
                            if (cmd == CMD_UNLOCK_2 && at_unlock2)
                                st_next.phase = PH_UNLOCKED;
                        PH_UNLOCKED:
                        begin
                            if (cmd == CMD_BUFFER)
                            begin
                                st_next.buffer_sector = addr;
                                st_next.phase         = PH_BUF_COUNT;
                            end
                            else if (at_unlock1)
                            begin
                                if (cmd == CMD_PROGRAM)
                                    st_next.phase = PH_PROG_DATA;
                                else if (cmd == CMD_ERASE_SETUP)
                                    st_next.phase = PH_ERASE_SETUP;
                                else if (cmd == CMD_AUTOSELECT)
                                    st_next.mode = MODE_AUTOSELECT;
                                else if (cmd == CMD_OTP)
                                    st_next.mode = MODE_OTP;
                            end
                        end
                        PH_PROG_DATA:
                        begin
                            res.command_valid   = 1'b1;
                            res.command_kind    = KIND_PROGRAM;
                            res.command_address = addr;
                            res.command_word    = data;
                            st_next.poll_target = data;
                            st_next.mode        = MODE_BUSY;
                        end
                        PH_ERASE_SETUP:
                            if (cmd == CMD_UNLOCK_1 && at_unlock1)
                                st_next.phase = PH_ERASE_UNLOCK1;
                        PH_ERASE_UNLOCK1:
                            if (cmd == CMD_UNLOCK_2 && at_unlock2)
                                st_next.phase = PH_ERASE_UNLOCKED;
                        PH_ERASE_UNLOCKED:
                        begin
                            if (cmd == CMD_ERASE_SECTOR)
                            begin
                                res.command_valid   = 1'b1;
                                res.command_kind    = KIND_ERASE_SECTOR;
                                res.command_address = addr;
                                st_next.poll_target = '1;
                                st_next.mode        = MODE_BUSY;
                            end
                            else if (cmd == CMD_ERASE_CHIP && at_unlock1)
                            begin
                                res.command_valid   = 1'b1;
                                res.command_kind    = KIND_ERASE_CHIP;
                                st_next.poll_target = '1;
                                st_next.mode        = MODE_BUSY;
                            end
                        end
                        PH_BUF_COUNT:
                        begin
                            if (data >= DATA_BITS'(BUFFER_WORDS))
                                st_next.mode = MODE_ABORT;
                            else
                            begin
                                st_next.words_left = data[LEFT_BITS-1:0];
                                st_next.phase      = PH_BUF_LOAD;
                            end
                        end
                        PH_BUF_LOAD:
                        begin
                            res.command_valid   = 1'b1;
                            res.command_kind    = KIND_LOAD_BUFFER;
                            res.command_address = addr;
                            res.command_word    = data;
                            st_next.poll_target = data;
                            if (st.words_left == '0)
                                st_next.phase = PH_BUF_CONFIRM;
                            else
                            begin
                                st_next.words_left = st.words_left - LEFT_BITS'(1);
                                st_next.phase      = PH_BUF_LOAD;
                            end
                        end
                        PH_BUF_CONFIRM:
                        begin
                            if (cmd == CMD_CONFIRM)
                            begin
                                res.command_valid   = 1'b1;
                                res.command_kind    = KIND_PROG_BUFFER;
                                res.command_address = st.buffer_sector;
                                st_next.mode        = MODE_BUSY;
                            end
                            else
                                st_next.mode = MODE_ABORT;
                        end
                        default: ;
                    endcase
                end
            end

            OP_DONE:
            begin
                if (st.mode == MODE_BUSY)
                begin
                    st_next.mode  = MODE_READ;
                    st_next.phase = PH_IDLE;
                end
            end

            default: ;
        endcase

        res.busy_res     = st_next.mode == MODE_BUSY;
        res.buffer_abort = st_next.mode == MODE_ABORT;
        res.otp_selected = st_next.mode == MODE_OTP;
    end
endmodule

### sv/nor_flash_command_decoder_top.sv
// ----------------------------------------------------------------------------
// nor_flash_command_decoder_top
// Command interface of a 16-bit NOR flash with the unlock-based command set.
//
// Channel item: one bus read, bus write or engine-done event per beat.
// Channel result: one beat per item, carrying read data, an optional
// program/erase/buffer command to the memory engine and the mode status.
// Config port: four autoselect id bytes, written with cfg_we, cfg_index,
// cfg_data while no item is in flight.
// Path: an accepted item lands in an input register, is decoded from there
// and its result is loaded into the output register once that can advance.
// Throughput: one item per cycle while result is taken; decoding one item
// against the sequence state is the only logic between the two registers.
// Stall: when result is not taken, the output register holds, the input
// register takes one more beat if it was empty, then item.ready drops.
// Reset: both registers empty, idle command phase, read array mode, poll
// target all ones, id bytes at their defaults.
// ----------------------------------------------------------------------------
module nor_flash_command_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nfcd_pkg::ID_BITS-1:0]        cfg_data,
    nfcd_req_if.sink                            item,
    nfcd_rsp_if.source                          result
);
    import nfcd_pkg::*;

    cfg_t    cfg;
    state_t  st_reg;
    state_t  st_next;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    nfcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nfcd_decode u_decode (
        .st      (st_reg),
        .item    (in_item_reg),
        .cfg     (cfg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign advance    = !res_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            res_valid_reg         <= 1'b0;
            st_reg.phase          <= PH_IDLE;
            st_reg.mode           <= MODE_READ;
            st_reg.poll_target    <= '1;
            st_reg.buffer_sector  <= '0;
            st_reg.words_left     <= '0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.operation    <= item.operation;
            in_item_reg.word_address <= item.word_address;
            in_item_reg.write_word   <= item.write_word;
            in_item_reg.array_word   <= item.array_word;
        end
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

    assign result.valid           = res_valid_reg;
    assign result.read_word       = res_reg.read_word;
    assign result.command_valid   = res_reg.command_valid;
    assign result.command_kind    = res_reg.command_kind;
    assign result.command_address = res_reg.command_address;
    assign result.command_word    = res_reg.command_word;
    assign result.busy_res        = res_reg.busy_res;
    assign result.buffer_abort    = res_reg.buffer_abort;
    assign result.otp_selected    = res_reg.otp_selected;
endmodule
